### hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/tsch_pkg.sv
`default_nettype none

package tsch_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int TIME_BITS_DEF   = 24;

  localparam int IDX_W      = 4;
  localparam int TIME_W     = 24;
  localparam int QUANTUM_W  = 16;
  localparam int CNT_W      = 5;
  localparam int POLICY_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET     = 16'd500;
  localparam logic [CNT_W-1:0]     ENTRY_COUNT_RESET = 5'd16;

  localparam logic [POLICY_W-1:0] POL_FIFO = 2'd0;
  localparam logic [POLICY_W-1:0] POL_RR   = 2'd1;
  localparam logic [POLICY_W-1:0] POL_SJF  = 2'd2;
  localparam logic [POLICY_W-1:0] POL_PSJF = 2'd3;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 2'd2;

  typedef struct packed {
    logic              operation;
    logic [IDX_W-1:0]  entry_index;
    logic [TIME_W-1:0] release_time;
    logic [TIME_W-1:0] exec_time;
  } in_word_t;

  typedef struct packed {
    logic             running_valid;
    logic [IDX_W-1:0] running_index;
    logic             finished_valid;
    logic [IDX_W-1:0] finished_index;
    logic             all_done;
  } out_word_t;

  // Controller to datapath.
  typedef struct packed {
    logic tick_start;
    logic load;
    logic chk;
    logic div_init;
    logic div_step;
    logic mod_step;
    logic scan_init;
    logic scan_issue;
    logic decide;
    logic finish;
    logic emit;
    logic run_show;
    logic fin_show;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic all_done;
    logic done_after;
    logic need_div;
    logic div_done;
    logic mod_done;
    logic scan_last;
  } stat_t;

endpackage

`default_nettype wire

### hw/rtl/tsch_ctrl.sv
`default_nettype none

module tsch_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic            op,
  input  wire tsch_pkg::stat_t st,
  output tsch_pkg::cmd_t       cmd,
  output logic                 busy
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHK    = 4'd1;
  localparam logic [3:0] S_FIN    = 4'd2;
  localparam logic [3:0] S_DIV    = 4'd3;
  localparam logic [3:0] S_MOD    = 4'd4;
  localparam logic [3:0] S_SINIT  = 4'd5;
  localparam logic [3:0] S_SCAN   = 4'd6;
  localparam logic [3:0] S_DRAIN  = 4'd7;
  localparam logic [3:0] S_DECIDE = 4'd8;
  localparam logic [3:0] S_RD2    = 4'd9;
  localparam logic [3:0] S_DEC    = 4'd10;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (op == tsch_pkg::OP_LOAD) begin
            cmd.load = 1'b1;
            cmd.emit = 1'b1;
          end else if (st.all_done) begin
            cmd.emit = 1'b1;
          end else begin
            cmd.tick_start = 1'b1;
            state_nxt      = S_CHK;
          end
        end
      end
      S_CHK: begin
        cmd.chk = 1'b1;
        if (st.done_after) begin
          state_nxt = S_FIN;
        end else if (st.need_div) begin
          cmd.div_init = 1'b1;
          state_nxt    = S_DIV;
        end else begin
          state_nxt = S_SINIT;
        end
      end
      S_FIN: begin
        cmd.emit     = 1'b1;
        cmd.fin_show = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_DIV: begin
        if (st.div_done) begin
          state_nxt = S_MOD;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_MOD: begin
        if (st.mod_done) begin
          state_nxt = S_SINIT;
        end else begin
          cmd.mod_step = 1'b1;
        end
      end
      S_SINIT: begin
        cmd.scan_init = 1'b1;
        state_nxt     = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (st.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = S_RD2;
      end
      S_RD2: begin
        state_nxt = S_DEC;
      end
      S_DEC: begin
        cmd.finish   = 1'b1;
        cmd.emit     = 1'b1;
        cmd.run_show = 1'b1;
        cmd.fin_show = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

### hw/rtl/tsch_dp.sv
`default_nettype none

module tsch_dp #(
  parameter int MAX_ENTRIES = tsch_pkg::MAX_ENTRIES_DEF,
  parameter int TIME_BITS   = tsch_pkg::TIME_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire tsch_pkg::cmd_t                       cmd,
  output tsch_pkg::stat_t                           st,
  input  wire tsch_pkg::in_word_t                   in_data,
  input  wire logic                                 cfg_we,
  input  wire logic [tsch_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [tsch_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic                                      out_valid,
  output tsch_pkg::out_word_t                       out_data
);

  localparam int IW    = $clog2(MAX_ENTRIES);
  localparam int CW    = $clog2(MAX_ENTRIES + 1);
  localparam int DCW   = $clog2(TIME_BITS + 1);
  localparam int QW    = tsch_pkg::QUANTUM_W;
  localparam int RW    = QW + 1;
  localparam int IDX_W = tsch_pkg::IDX_W;

  // configuration
  logic [tsch_pkg::POLICY_W-1:0] policy_r;
  logic [QW-1:0]                 quantum_r;
  logic [tsch_pkg::CNT_W-1:0]    entry_count_r;

  // tables
  logic [TIME_BITS-1:0] rel_mem [MAX_ENTRIES];
  logic [TIME_BITS-1:0] rem_mem [MAX_ENTRIES];
  logic [TIME_BITS-1:0] rd_rel_r;
  logic [TIME_BITS-1:0] rd_rem_r;

  // scheduler state
  logic [MAX_ENTRIES-1:0] arr_r;
  logic                   flag_r;
  logic [IW-1:0]          running_r;
  logic [TIME_BITS-1:0]   time_r;
  logic [TIME_BITS-1:0]   last_sw_r;
  logic [CW-1:0]          retired_r;
  logic                   fin_v_r;
  logic [IW-1:0]          fin_idx_r;

  // quantum check and rotation start
  logic [TIME_BITS-1:0] dv_r;
  logic [RW-1:0]        drem_r;
  logic [DCW-1:0]       dcnt_r;
  logic [CW-1:0]        s_r;

  // scan
  logic [IW-1:0]        scan_i_r;
  logic                 pend_r;
  logic [IW-1:0]        pend_idx_r;
  logic                 best_v_r;
  logic [IW-1:0]        best_idx_r;
  logic [TIME_BITS-1:0] best_key_r;
  logic                 first_v_r;
  logic [IW-1:0]        first_idx_r;
  logic                 hi_v_r;
  logic [IW-1:0]        hi_idx_r;

  logic                  out_valid_r;
  tsch_pkg::out_word_t   out_data_r;
  tsch_pkg::out_word_t   out_nxt;

  logic [CW-1:0]        n_use;
  logic [QW-1:0]        q_eff;
  logic                 load_ok;
  logic [IW-1:0]        load_addr;
  logic [IW-1:0]        ra;
  logic [IW-1:0]        wa;
  logic                 rel_we;
  logic                 rem_we;
  logic [TIME_BITS-1:0] wrem;
  logic                 retire_now;
  logic                 arr_new;
  logic                 cand;
  logic [TIME_BITS-1:0] key;
  logic [RW-1:0]        div_try;
  logic                 elapsed;
  logic                 sel_v;
  logic [IW-1:0]        sel_idx;
  logic                 switch_now;

  always_comb begin
    if (entry_count_r == '0) begin
      n_use = CW'(1);
    end else if (int'(entry_count_r) > MAX_ENTRIES) begin
      n_use = CW'(MAX_ENTRIES);
    end else begin
      n_use = CW'(entry_count_r);
    end
  end

  assign q_eff     = (quantum_r == '0) ? QW'(1) : quantum_r;
  assign load_ok   = int'(in_data.entry_index) < MAX_ENTRIES;
  assign load_addr = IW'(in_data.entry_index);
  assign ra        = cmd.scan_issue ? scan_i_r : running_r;
  assign wa        = cmd.load ? load_addr : running_r;
  assign rel_we    = cmd.load && load_ok;
  assign rem_we    = (cmd.load && load_ok) || (cmd.finish && flag_r && (rd_rem_r != '0));
  assign wrem      = cmd.load ? TIME_BITS'(in_data.exec_time) : (rd_rem_r - 1'b1);

  always_ff @(posedge clk) begin
    if (rel_we) begin
      rel_mem[wa] <= TIME_BITS'(in_data.release_time);
    end
    if (rem_we) begin
      rem_mem[wa] <= wrem;
    end
    rd_rel_r <= rel_mem[ra];
    rd_rem_r <= rem_mem[ra];
  end

  assign retire_now = flag_r && (rd_rem_r == '0);

  // scan compare on the word read for pend_idx_r
  assign arr_new = arr_r[pend_idx_r] | (rd_rel_r == time_r);
  assign cand    = arr_new && (rd_rem_r != '0);
  assign key     = (policy_r == tsch_pkg::POL_FIFO) ? rd_rel_r : rd_rem_r;

  assign div_try = {drem_r[RW-2:0], dv_r[TIME_BITS-1]};
  assign elapsed = (drem_r == '0);

  always_comb begin
    sel_v   = 1'b0;
    sel_idx = running_r;
    case (policy_r) inside
      tsch_pkg::POL_FIFO, tsch_pkg::POL_SJF: begin
        if (!flag_r) begin
          sel_v   = best_v_r;
          sel_idx = best_idx_r;
        end
      end
      tsch_pkg::POL_PSJF: begin
        sel_v   = best_v_r;
        sel_idx = best_idx_r;
      end
      tsch_pkg::POL_RR: begin
        if (!flag_r || elapsed) begin
          if (flag_r && hi_v_r) begin
            sel_v   = 1'b1;
            sel_idx = hi_idx_r;
          end else begin
            sel_v   = first_v_r;
            sel_idx = first_idx_r;
          end
        end
      end
      default: begin
        sel_v = 1'b0;
      end
    endcase
  end

  assign switch_now = sel_v && (!flag_r || (sel_idx != running_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r      <= tsch_pkg::POL_FIFO;
      quantum_r     <= tsch_pkg::QUANTUM_RESET;
      entry_count_r <= tsch_pkg::ENTRY_COUNT_RESET;
      arr_r         <= '0;
      flag_r        <= 1'b0;
      running_r     <= '0;
      time_r        <= '0;
      last_sw_r     <= '0;
      retired_r     <= '0;
      fin_v_r       <= 1'b0;
      pend_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          tsch_pkg::CFG_POLICY:      policy_r      <= cfg_wdata[tsch_pkg::POLICY_W-1:0];
          tsch_pkg::CFG_QUANTUM:     quantum_r     <= cfg_wdata[QW-1:0];
          tsch_pkg::CFG_ENTRY_COUNT: entry_count_r <= cfg_wdata[tsch_pkg::CNT_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.tick_start) begin
        fin_v_r <= 1'b0;
      end
      if (cmd.chk && retire_now) begin
        fin_v_r   <= 1'b1;
        flag_r    <= 1'b0;
        retired_r <= retired_r + 1'b1;
      end
      pend_r <= cmd.scan_issue;
      if (pend_r) begin
        arr_r[pend_idx_r] <= arr_new;
      end
      if (cmd.decide && switch_now) begin
        last_sw_r <= time_r;
        running_r <= sel_idx;
        flag_r    <= 1'b1;
      end
      if (cmd.finish) begin
        time_r <= time_r + 1'b1;
      end
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.chk && retire_now) begin
      fin_idx_r <= running_r;
    end
    if (cmd.div_init) begin
      dv_r   <= time_r - last_sw_r;
      drem_r <= '0;
      dcnt_r <= DCW'(TIME_BITS);
      s_r    <= CW'(running_r) + 1'b1;
    end
    if (cmd.div_step) begin
      dv_r   <= dv_r << 1;
      dcnt_r <= dcnt_r - 1'b1;
      if (div_try >= {1'b0, q_eff}) begin
        drem_r <= div_try - {1'b0, q_eff};
      end else begin
        drem_r <= div_try;
      end
    end
    if (cmd.mod_step) begin
      s_r <= s_r - n_use;
    end
    if (cmd.scan_init) begin
      scan_i_r  <= '0;
      best_v_r  <= 1'b0;
      first_v_r <= 1'b0;
      hi_v_r    <= 1'b0;
    end
    if (cmd.scan_issue) begin
      scan_i_r   <= scan_i_r + 1'b1;
      pend_idx_r <= scan_i_r;
    end
    if (pend_r && cand) begin
      if (!best_v_r || (key < best_key_r)) begin
        best_v_r   <= 1'b1;
        best_idx_r <= pend_idx_r;
        best_key_r <= key;
      end
      if (!first_v_r) begin
        first_v_r   <= 1'b1;
        first_idx_r <= pend_idx_r;
      end
      if (!hi_v_r && (CW'(pend_idx_r) >= s_r)) begin
        hi_v_r   <= 1'b1;
        hi_idx_r <= pend_idx_r;
      end
    end
    if (cmd.emit) begin
      out_data_r <= out_nxt;
    end
  end

  always_comb begin
    out_nxt.running_valid  = cmd.run_show && flag_r;
    out_nxt.running_index  = (cmd.run_show && flag_r) ? IDX_W'(running_r) : '0;
    out_nxt.finished_valid = cmd.fin_show && fin_v_r;
    out_nxt.finished_index = (cmd.fin_show && fin_v_r) ? IDX_W'(fin_idx_r) : '0;
    out_nxt.all_done       = (retired_r >= n_use);
  end

  always_comb begin
    st.all_done   = (retired_r >= n_use);
    st.done_after = retire_now && (CW'(retired_r + 1'b1) >= n_use);
    st.need_div   = (policy_r == tsch_pkg::POL_RR) && flag_r && !retire_now;
    st.div_done   = (dcnt_r == '0);
    st.mod_done   = (s_r < n_use);
    st.scan_last  = (CW'(scan_i_r) == (n_use - 1'b1));
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### hw/rtl/task_scheduler_fifo_rr_sjf.sv
// Tick-driven task scheduler over a table of MAX_ENTRIES entries.
// Input: a word is taken on a rising edge with start high and busy low.
//   operation load writes one entry's release time and run length; the
//   result word (no run, no retire, current all_done) shows in the next cycle.
//   operation tick retires, marks arrivals, picks per policy (FIFO, round
//   robin, SJF, preemptive SJF), charges one tick to the running entry and
//   advances the clock of the schedule.
// Output: out_valid strobes for exactly one cycle per input word; the
//   receiver cannot hold it off and must take it then.
// Timing: a load, or a tick after all entries are done, raises no busy.
//   A tick that retires the last entry holds busy through check and finish;
//   any other tick through check, one table pass at one entry per cycle,
//   decide and charge. Round robin with an entry still running adds the
//   bit-serial slice check and the wrap of the rotation start.
//   The result strobes in the first cycle busy is low; the next word may go then.
// Config: cfg_we writes register cfg_index (0 policy, 1 quantum,
//   2 entry_count) at once; write only while busy is low.
// Reset: rst_n (synchronous) restores register defaults and clears the
//   arrival flags, time and counters; table contents are kept.
`default_nettype none

module task_scheduler_fifo_rr_sjf #(
  parameter int MAX_ENTRIES = tsch_pkg::MAX_ENTRIES_DEF,
  parameter int TIME_BITS   = tsch_pkg::TIME_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire tsch_pkg::in_word_t                in_data,
  input  wire logic                              cfg_we,
  input  wire logic [tsch_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tsch_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic                                   out_valid,
  output tsch_pkg::out_word_t                    out_data
);

  // command and status between sequencer and datapath
  tsch_pkg::cmd_t  cmd;
  tsch_pkg::stat_t st;

  // sequence each tick word: check, slice test, table pass, decide, charge
  tsch_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (in_data.operation),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  // hold tables, schedule state, config and the result register
  tsch_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### hw/rtl/tsch_checker.sv
`default_nettype none
`include "assert_macros.svh"

module tsch_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire tsch_pkg::in_word_t  in_data,
  input wire logic                out_valid,
  input wire tsch_pkg::out_word_t out_data
);

  logic in_acc;
  logic load_acc;
  logic idle_word;
  logic run_shown;

  assign in_acc    = start && !busy;
  assign load_acc  = in_acc && (in_data.operation == tsch_pkg::OP_LOAD);
  assign idle_word = !out_data.running_valid && !out_data.finished_valid;
  assign run_shown = out_valid && out_data.running_valid;

  // a result word follows an accept in idle or the end of a busy stretch
  `CHK_IMPL(a_result_source, out_valid, $past(in_acc) || $fell(busy), "stray result word")

  `CHK_IMPL(a_busy_end_emits, $fell(busy), out_valid, "busy dropped without a result word")

  `CHK_NEXT(a_load_result, load_acc, out_valid && idle_word, "load result wrong")

  `CHK_IMPL(a_run_not_done, run_shown, !out_data.all_done, "entry ran after all done")

endmodule

bind task_scheduler_fifo_rr_sjf tsch_checker u_tsch_checker (.*);

`default_nettype wire

### verif/task_scheduler_fifo_rr_sjf_test.sv
module task_scheduler_fifo_rr_sjf_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tsch_pkg::*;

  localparam int TBL_DEPTH   = MAX_ENTRIES_DEF;
  localparam int ITEM_TARGET = 1600;
  // A tick runs a table pass, round robin adds a slice check and wraps;
  // allow several times the slowest run with the longest sender gaps.
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 80;
  // Stop handing out short run lengths once this many retirements happened,
  // so the table never reaches the all-retired state for good.
  localparam int RETIRE_GATE = 9;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  in_word_t              in_data   = '0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  out_valid;
  out_word_t             out_data;

  task_scheduler_fifo_rr_sjf u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // ---------------------------------------------------------------------
  // Scheduler image: configuration and table state, kept in step with the
  // words the block accepts.
  // ---------------------------------------------------------------------
  logic [POLICY_W-1:0]  pol_cfg     = POL_FIFO;
  logic [QUANTUM_W-1:0] quantum_cfg = QUANTUM_RESET;
  logic [CNT_W-1:0]     count_cfg   = ENTRY_COUNT_RESET;

  logic [TIME_W-1:0] rel_tab [TBL_DEPTH] = '{default: '0};
  logic [TIME_W-1:0] rem_tab [TBL_DEPTH] = '{default: '0};
  logic              arrived [TBL_DEPTH] = '{default: 1'b0};
  logic              run_flag    = 1'b0;
  logic [IDX_W-1:0]  run_ent     = '0;
  logic [TIME_W-1:0] now_tick    = '0;
  logic [TIME_W-1:0] slice_start = '0;
  logic [CNT_W-1:0]  retired     = '0;

  in_word_t  cmd_q [$];      // words waiting to be offered
  out_word_t outcome_q [$];  // predicted outcome of each accepted word

  int        errors = 0;
  int        issued = 0;
  int        cycles = 0;
  int        phase_no = 0;
  int        gap_left = 0;
  int        burst_left = 0;
  logic      holding = 1'b0;
  logic      offer;
  out_word_t want;

  // Entry count as the block uses it: zero acts as one, large values clamp.
  function automatic int active_count();
    if (count_cfg == 0) return 1;
    if (count_cfg > TBL_DEPTH) return TBL_DEPTH;
    return int'(count_cfg);
  endfunction

  function automatic logic ready(int i, int n);
    return i < n && arrived[i] && rem_tab[i] != '0;
  endfunction

  // Return the entry to run next, -1 when nothing qualifies.
  function automatic int choose_entry(int n);
    int                best;
    int                i;
    int                k;
    int                j;
    logic [TIME_W-1:0] span;
    int unsigned       slice;
    best = -1;
    // FIFO and SJF never take the processor away from a running entry.
    if (run_flag && (pol_cfg == POL_FIFO || pol_cfg == POL_SJF)) return int'(run_ent);
    if (pol_cfg == POL_RR) begin
      slice = (quantum_cfg == '0) ? 1 : quantum_cfg;
      if (!run_flag) begin
        for (i = 0; i < n; i++) if (ready(i, n)) return i;
        return -1;
      end
      span = now_tick - slice_start;
      if (span % slice == 0) begin
        // Search after the running entry, wrap, and try it last.
        for (k = 1; k <= n; k++) begin
          j = (int'(run_ent) + k) % n;
          if (ready(j, n)) return j;
        end
        return -1;
      end
      return int'(run_ent);
    end
    for (i = 0; i < n; i++) begin
      if (!ready(i, n)) continue;
      if (best < 0) best = i;
      else if (pol_cfg == POL_FIFO) begin
        if (rel_tab[i] < rel_tab[best]) best = i;
      end else if (rem_tab[i] < rem_tab[best]) begin
        best = i;
      end
    end
    return best;
  endfunction

  // Apply one accepted word to the image and return the word it must produce.
  function automatic out_word_t schedule_word(in_word_t w);
    out_word_t r;
    int        n;
    int        nxt;
    int        i;
    r = '0;
    n = active_count();
    if (w.operation == OP_LOAD) begin
      rel_tab[w.entry_index] = w.release_time;
      rem_tab[w.entry_index] = w.exec_time;
    end else if (int'(retired) < n) begin
      if (run_flag && rem_tab[run_ent] == '0) begin
        r.finished_valid = 1'b1;
        r.finished_index = run_ent;
        run_flag = 1'b0;
        retired  = retired + 1'b1;
      end
      if (int'(retired) < n) begin
        for (i = 0; i < n; i++) if (rel_tab[i] == now_tick) arrived[i] = 1'b1;
        nxt = choose_entry(n);
        if (nxt >= 0 && (!run_flag || nxt != int'(run_ent))) begin
          slice_start = now_tick;
          run_ent     = nxt[IDX_W-1:0];
          run_flag    = 1'b1;
        end
        if (run_flag) begin
          r.running_valid = 1'b1;
          r.running_index = run_ent;
          if (rem_tab[run_ent] != '0) rem_tab[run_ent] = rem_tab[run_ent] - 1'b1;
        end
        now_tick = now_tick + 1'b1;
      end
    end
    r.all_done = int'(retired) >= n;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Clock, reset and run limit.
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    errors++;
    $display("MISMATCH at cycle %0d: %s", cycles, msg);
  endtask

  // ---------------------------------------------------------------------
  // Driver: pull the next word from cmd_q, hold it back for a random gap,
  // then raise start until the block takes it. Predict on acceptance.
  // ---------------------------------------------------------------------
  function automatic int draw_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    // Now and then open a run of back-to-back words.
    if ($urandom_range(0, 24) == 0) begin
      burst_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      offer = start;
      if (start && !busy) begin
        outcome_q.push_back(schedule_word(in_data));
        holding = 1'b0;
        offer   = 1'b0;
      end
      if (!holding && cmd_q.size() != 0) begin
        in_data  <= cmd_q.pop_front();
        holding  = 1'b1;
        gap_left = draw_gap();
      end
      // Count the gap down, then present the word; keep start high while
      // the next word follows without a gap.
      if (holding && !offer) begin
        if (gap_left == 0) offer = 1'b1;
        else gap_left--;
      end
      start <= offer;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: every strobe must match the oldest prediction, field by field.
  // ---------------------------------------------------------------------
  task automatic check_field(string name, int got, int exp_val);
    if (got != exp_val)
      report_mismatch($sformatf("%s got %0d want %0d", name, got, exp_val));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (outcome_q.size() == 0) begin
        report_mismatch($sformatf("result word %h with nothing outstanding", out_data));
      end else begin
        want = outcome_q.pop_front();
        check_field("running_valid", out_data.running_valid, want.running_valid);
        check_field("running_index", out_data.running_index, want.running_index);
        check_field("finished_valid", out_data.finished_valid, want.finished_valid);
        check_field("finished_index", out_data.finished_index, want.finished_index);
        check_field("all_done", out_data.all_done, want.all_done);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------
  task automatic queue_load(int idx, logic [TIME_W-1:0] rel, logic [TIME_W-1:0] exe);
    in_word_t w;
    w.operation    = OP_LOAD;
    w.entry_index  = idx[IDX_W-1:0];
    w.release_time = rel;
    w.exec_time    = exe;
    cmd_q.push_back(w);
    issued++;
  endtask

  // Tick words carry random junk in the unused fields.
  task automatic queue_tick();
    in_word_t w;
    w.operation    = OP_TICK;
    w.entry_index  = IDX_W'($urandom());
    w.release_time = TIME_W'($urandom());
    w.exec_time    = TIME_W'($urandom());
    cmd_q.push_back(w);
    issued++;
  endtask

  // Hold until every queued word is taken and every result has come back.
  task automatic wait_quiet();
    while (cmd_q.size() != 0 || holding || outcome_q.size() != 0) @(posedge clk);
  endtask

  // Write one register while the block is idle and mirror it in the image.
  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    case (idx)
      CFG_POLICY:      pol_cfg     = POLICY_W'(val);
      CFG_QUANTUM:     quantum_cfg = QUANTUM_W'(val);
      CFG_ENTRY_COUNT: count_cfg   = CNT_W'(val);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One phase: new settings, a reload pass over the table with release
  // times just ahead of the schedule clock, then a run of ticks mixed with
  // stray loads. The sender pauses at the end until all results are back.
  task automatic run_phase();
    int                ticks;
    int                i;
    int                lo;
    int                cnt;
    int                qv;
    int                smalls;
    logic              gated;
    logic [TIME_W-1:0] rel;
    logic [TIME_W-1:0] exe;
    phase_no++;
    set_reg(CFG_POLICY, (phase_no <= 8) ? (phase_no % 4) : $urandom_range(0, 3));
    case ($urandom_range(0, 7))
      0:       qv = 0;
      1:       qv = 65535;
      2:       qv = 500;
      3:       qv = $urandom_range(0, 65535);
      default: qv = $urandom_range(1, 6);
    endcase
    set_reg(CFG_QUANTUM, qv);
    // Keep the entry count mostly above the retirements so ticks do work.
    lo = int'(retired) + 2;
    if (lo > TBL_DEPTH) lo = TBL_DEPTH;
    case ($urandom_range(0, 7))
      0:       cnt = 0;
      1:       cnt = $urandom_range(TBL_DEPTH + 1, 31);
      2:       cnt = 1;
      default: cnt = $urandom_range(lo, TBL_DEPTH);
    endcase
    set_reg(CFG_ENTRY_COUNT, cnt);

    ticks  = $urandom_range(20, 50);
    gated  = int'(retired) >= RETIRE_GATE;
    smalls = 0;
    for (i = 0; i < TBL_DEPTH; i++) begin
      // Once retirements run high, reload every entry with a long or a zero
      // run time, so no short run lengths are handed out any more.
      if (gated || $urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 15))
          0:       rel = TIME_W'($urandom());
          1:       rel = now_tick - 1'b1;
          default: rel = now_tick + TIME_W'($urandom_range(0, ticks));
        endcase
        case ($urandom_range(0, 9))
          0:       exe = '0;
          1, 2:    begin
            if (!gated && smalls < 3) begin
              smalls++;
              exe = TIME_W'($urandom_range(1, 10));
            end else begin
              exe = TIME_W'($urandom_range(3000, 60000));
            end
          end
          3:       exe = TIME_W'($urandom_range(24'hFFFFFF, 3000));
          default: exe = gated ? TIME_W'($urandom_range(3000, 60000))
                               : TIME_W'($urandom_range(30, 2000));
        endcase
        queue_load(i, rel, exe);
      end
    end
    for (i = 0; i < ticks; i++) begin
      if ($urandom_range(0, 9) == 0)
        queue_load($urandom_range(0, TBL_DEPTH - 1), TIME_W'($urandom()),
                   TIME_W'($urandom_range(24'hFFFFFF, 3000)));
      queue_tick();
    end
    wait_quiet();
  endtask

  // ---------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Fill the whole table first so no tick ever reads an unloaded entry.
    // Entries 0 and 1 tie on release time, entry 3 has no work at all, and
    // the upper entries never arrive.
    queue_load(0, 24'd0, 24'd3);
    queue_load(1, 24'd0, 24'd1);
    queue_load(2, 24'd1, 24'd2);
    queue_load(3, 24'd2, 24'd0);
    for (int i = 4; i < TBL_DEPTH - 1; i++)
      queue_load(i, 24'hFFFFFF, TIME_W'($urandom()));
    queue_load(TBL_DEPTH - 1, 24'hFFFFFF, 24'hFFFFFF);
    // FIFO at reset: run 0, 1, 2 to completion, then idle with nothing ready.
    repeat (7) queue_tick();
    wait_quiet();

    // Shrink below the retirements: ticks freeze and show only all_done.
    set_reg(CFG_ENTRY_COUNT, 2);
    repeat (2) queue_tick();
    wait_quiet();
    // A zero entry count acts as one.
    set_reg(CFG_ENTRY_COUNT, 0);
    queue_tick();
    queue_load(4, 24'h000000, 24'hFFFFFF);
    wait_quiet();

    while (issued < ITEM_TARGET) run_phase();

    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
